FILE: src/ypld_pkg.sv
// Shared constants, types and the arctangent table for the look-direction block.
// No dependencies; ypld_cordic, ypld_mul and the top level in src import this package.
package ypld_pkg;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned CORDIC_CNT_W = $clog2(CORDIC_STEPS);

  localparam int unsigned GAIN_W = 24;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd4096;

  localparam logic signed [31:0] CORDIC_K    = 32'sd652032874;
  localparam logic signed [31:0] PITCH_LIMIT = 32'sd1073058259;

  typedef struct packed {
    logic               done;
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;
  } cs_res_t;

  function automatic logic [29:0] ypld_atan(input logic [4:0] idx);
    logic [29:0] r;
    case (idx)
      5'd0:    r = 30'd536870912;
      5'd1:    r = 30'd316933406;
      5'd2:    r = 30'd167458907;
      5'd3:    r = 30'd85004756;
      5'd4:    r = 30'd42667331;
      5'd5:    r = 30'd21354465;
      5'd6:    r = 30'd10679838;
      5'd7:    r = 30'd5340245;
      5'd8:    r = 30'd2670163;
      5'd9:    r = 30'd1335087;
      5'd10:   r = 30'd667544;
      5'd11:   r = 30'd333772;
      5'd12:   r = 30'd166886;
      5'd13:   r = 30'd83443;
      5'd14:   r = 30'd41722;
      5'd15:   r = 30'd20861;
      5'd16:   r = 30'd10430;
      5'd17:   r = 30'd5215;
      5'd18:   r = 30'd2608;
      5'd19:   r = 30'd1304;
      5'd20:   r = 30'd652;
      5'd21:   r = 30'd326;
      5'd22:   r = 30'd163;
      5'd23:   r = 30'd81;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: src/ypld_if.sv
// Valid/ready channel interfaces for the input and result beats.
// No dependencies.
interface ypld_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] motion_x;
  logic signed [15:0] motion_y;
  logic               focused;
  logic signed [31:0] eye_x;
  logic signed [31:0] eye_y;
  logic signed [31:0] eye_z;

  modport source (output valid, motion_x, motion_y, focused, eye_x, eye_y, eye_z,
                  input ready);
  modport sink   (input valid, motion_x, motion_y, focused, eye_x, eye_y, eye_z,
                  output ready);
endinterface

interface ypld_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] look_x;
  logic signed [31:0] look_y;
  logic signed [31:0] look_z;
  logic        [31:0] heading;
  logic signed [30:0] elevation;

  modport source (output valid, look_x, look_y, look_z, heading, elevation,
                  input ready);
  modport sink   (input valid, look_x, look_y, look_z, heading, elevation,
                  output ready);
endinterface

FILE: src/ypld_cordic.sv
// Iterative rotation-mode CORDIC giving cosine and sine, in Q2.30, of a 32-bit binary angle.
// Depends on ypld_pkg for the step count, gain constant and arctangent table.
module ypld_cordic import ypld_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic       [31:0] angle_i,
  output cs_res_t           res_o
);

  logic                    run_q, run_d;
  logic                    done_q, done_d;
  logic [CORDIC_CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]              quad_q, quad_d;
  logic signed [31:0]      x_q, x_d, y_q, y_d, z_q, z_d;
  logic signed [31:0]      x_sh, y_sh, at_v;
  logic [1:0]              quad_in;

  always_comb begin
    quad_in = 2'(((angle_i + 32'h2000_0000) >> 30));
    x_sh    = x_q >>> cnt_q;
    y_sh    = y_q >>> cnt_q;
    at_v    = signed'({2'b00, ypld_atan(5'(cnt_q))});
    run_d   = run_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quad_d  = quad_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    if (start_i && !run_q) begin
      run_d  = 1'b1;
      cnt_d  = '0;
      quad_d = quad_in;
      x_d    = CORDIC_K;
      y_d    = '0;
      z_d    = signed'(angle_i - {quad_in, 30'b0});
    end else if (run_q) begin
      if (!z_q[31]) begin
        x_d = x_q - y_sh;
        y_d = y_q + x_sh;
        z_d = z_q - at_v;
      end else begin
        x_d = x_q + y_sh;
        y_d = y_q - x_sh;
        z_d = z_q + at_v;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CORDIC_CNT_W'(CORDIC_STEPS - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    quad_q <= quad_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
  end

  always_comb begin
    res_o.done = done_q;
    case (quad_q)
      2'd0: begin
        res_o.cos_v = x_q;
        res_o.sin_v = y_q;
      end
      2'd1: begin
        res_o.cos_v = -y_q;
        res_o.sin_v = x_q;
      end
      2'd2: begin
        res_o.cos_v = -x_q;
        res_o.sin_v = -y_q;
      end
      default: begin
        res_o.cos_v = y_q;
        res_o.sin_v = -x_q;
      end
    endcase
  end

endmodule

FILE: src/ypld_mul.sv
// Shared 32 by 32 signed multiplier with a registered product.
// Depends on ypld_pkg only through the common import convention.
module ypld_mul import ypld_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [63:0] prod_o
);

  logic signed [63:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

FILE: src/yaw_pitch_look_direction.sv
// Top level of the look-direction block: sequencer, angle state and output register.
// Depends on ypld_pkg, ypld_if, ypld_cordic and ypld_mul.
//
// Each input beat optionally turns yaw and pitch by the pointer motion times
// mouse_gain, clamps pitch just short of straight up or down, and returns one
// result beat holding the eye position plus the unit look vector, saturated
// to Q16.16, together with the updated heading and elevation. Input beats are
// taken only in the idle state: ready drops after each acceptance until the
// item has passed the gain, clamp, CORDIC and direction states, and stays low
// longer while a finished result waits for a full output register to drain.
// The single CORDIC unit runs once for pitch and once for yaw, and the shared
// multiplier serves both the gain products and the direction products. A
// finished result sits in an output register, so the next beat can be taken
// while it waits. Write mouse_gain only while no item is in flight.
module yaw_pitch_look_direction import ypld_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [GAIN_W-1:0] cfg_wdata_i,
  ypld_in_if.sink           in_ch,
  ypld_out_if.source        out_ch
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_GX   = 10'b00_0000_0010,
    ST_GY   = 10'b00_0000_0100,
    ST_PIT  = 10'b00_0000_1000,
    ST_CPS  = 10'b00_0001_0000,
    ST_CPW  = 10'b00_0010_0000,
    ST_CYW  = 10'b00_0100_0000,
    ST_MDX  = 10'b00_1000_0000,
    ST_MDZ  = 10'b01_0000_0000,
    ST_FIN  = 10'b10_0000_0000
  } state_e;

  localparam logic signed [41:0] PitHi = 42'(PITCH_LIMIT);
  localparam logic signed [41:0] PitLo = -PitHi;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] s);
    logic signed [31:0] r;
    if (s[32] != s[31]) begin
      r = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  state_e             state_q, state_d;
  logic [GAIN_W-1:0]  gain_q;
  logic [31:0]        yaw_q, yaw_d;
  logic signed [31:0] pitch_q, pitch_d;
  logic               out_vld_q, out_vld_d;

  logic signed [15:0] mx_q, my_q;
  logic               foc_q;
  logic signed [31:0] eye_x_q, eye_y_q, eye_z_q;
  logic signed [31:0] cp_q, sp_q, cy_q, sy_q;
  logic signed [31:0] lookx_q;
  logic signed [31:0] out_x_q, out_y_q, out_z_q;
  logic [31:0]        out_head_q;
  logic signed [30:0] out_elev_q;

  logic               mul_en;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;

  logic               cor_start;
  logic [31:0]        cor_angle;
  cs_res_t            cor_res;

  logic signed [41:0] pit_sub, pit_diff;
  logic signed [63:0] rnd_xz;
  logic signed [19:0] d_xz;
  logic signed [32:0] rnd_y;
  logic signed [18:0] d_y;
  logic signed [31:0] look_x_v, look_y_v, look_z_v;
  logic               out_load;

  ypld_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  ypld_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .angle_i (cor_angle),
    .res_o   (cor_res)
  );

  always_comb begin
    pit_sub  = foc_q ? prod[41:0] : '0;
    pit_diff = {{10{pitch_q[31]}}, pitch_q} - pit_sub;
    rnd_xz   = prod + 64'sh0000_0800_0000_0000;
    d_xz     = rnd_xz[63:44];
    rnd_y    = {sp_q[31], sp_q} + 33'sd8192;
    d_y      = rnd_y[32:14];
    look_x_v = sat32({eye_x_q[31], eye_x_q} + {{13{d_xz[19]}}, d_xz});
    look_y_v = sat32({eye_y_q[31], eye_y_q} + {{14{d_y[18]}}, d_y});
    look_z_v = sat32({eye_z_q[31], eye_z_q} + {{13{d_xz[19]}}, d_xz});
  end

  always_comb begin
    state_d   = state_q;
    yaw_d     = yaw_q;
    pitch_d   = pitch_q;
    mul_en    = 1'b0;
    mul_a     = cp_q;
    mul_b     = sy_q;
    cor_start = 1'b0;
    cor_angle = pitch_q;
    out_load  = 1'b0;
    out_vld_d = out_vld_q && !out_ch.ready;
    case (state_q)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_d = ST_GX;
        end
      end
      ST_GX: begin
        mul_en  = 1'b1;
        mul_a   = {{16{mx_q[15]}}, mx_q};
        mul_b   = signed'({8'b0, gain_q});
        state_d = ST_GY;
      end
      ST_GY: begin
        mul_en  = 1'b1;
        mul_a   = {{16{my_q[15]}}, my_q};
        mul_b   = signed'({8'b0, gain_q});
        if (foc_q) begin
          yaw_d = yaw_q - prod[31:0];
        end
        state_d = ST_PIT;
      end
      ST_PIT: begin
        if (pit_diff > PitHi) begin
          pitch_d = PITCH_LIMIT;
        end else if (pit_diff < PitLo) begin
          pitch_d = -PITCH_LIMIT;
        end else begin
          pitch_d = pit_diff[31:0];
        end
        state_d = ST_CPS;
      end
      ST_CPS: begin
        cor_start = 1'b1;
        state_d   = ST_CPW;
      end
      ST_CPW: begin
        cor_angle = yaw_q;
        if (cor_res.done) begin
          cor_start = 1'b1;
          state_d   = ST_CYW;
        end
      end
      ST_CYW: begin
        if (cor_res.done) begin
          state_d = ST_MDX;
        end
      end
      ST_MDX: begin
        mul_en  = 1'b1;
        mul_a   = cp_q;
        mul_b   = sy_q;
        state_d = ST_MDZ;
      end
      ST_MDZ: begin
        mul_en  = 1'b1;
        mul_a   = cp_q;
        mul_b   = cy_q;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_vld_q || out_ch.ready) begin
          out_load  = 1'b1;
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      gain_q    <= GAIN_RESET;
      yaw_q     <= '0;
      pitch_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      yaw_q     <= yaw_d;
      pitch_q   <= pitch_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        gain_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_ch.valid) begin
      mx_q    <= in_ch.motion_x;
      my_q    <= in_ch.motion_y;
      foc_q   <= in_ch.focused;
      eye_x_q <= in_ch.eye_x;
      eye_y_q <= in_ch.eye_y;
      eye_z_q <= in_ch.eye_z;
    end
    if (state_q == ST_CPW && cor_res.done) begin
      cp_q <= cor_res.cos_v;
      sp_q <= cor_res.sin_v;
    end
    if (state_q == ST_CYW && cor_res.done) begin
      cy_q <= cor_res.cos_v;
      sy_q <= cor_res.sin_v;
    end
    if (state_q == ST_MDZ) begin
      lookx_q <= look_x_v;
    end
    if (out_load) begin
      out_x_q    <= lookx_q;
      out_y_q    <= look_y_v;
      out_z_q    <= look_z_v;
      out_head_q <= yaw_q;
      out_elev_q <= pitch_q[30:0];
    end
  end

  assign in_ch.ready      = (state_q == ST_IDLE);
  assign out_ch.valid     = out_vld_q;
  assign out_ch.look_x    = out_x_q;
  assign out_ch.look_y    = out_y_q;
  assign out_ch.look_z    = out_z_q;
  assign out_ch.heading   = out_head_q;
  assign out_ch.elevation = out_elev_q;

endmodule

FILE: tb/sv/ypld_look_checker.sv
// Scoreboard for the look-direction block: it watches the config port and both channels,
// predicts each result beat from the accepted input beats, and compares field by field.
// Depends on ypld_pkg and ypld_if.
module ypld_look_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ypld_pkg::GAIN_W-1:0] cfg_wdata_i,
  ypld_in_if                         in_ch,
  ypld_out_if                        out_ch,
  output int                         fail_count_o,
  output int                         pending_o,
  output int                         results_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ypld_pkg::*;

  localparam longint ELEV_LIMIT = 64'sd1073058259;
  localparam longint UNIT_GAIN  = 64'sd652032874;
  localparam longint ROUND_XZ   = 64'sd8796093022208;
  localparam longint ROUND_Y    = 64'sd8192;
  localparam longint INT32_MAX  = 64'sd2147483647;
  localparam longint INT32_MIN  = -64'sd2147483648;
  localparam int     ATAN_DEPTH = 24;
  localparam longint ATAN_TURNS [ATAN_DEPTH] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef struct packed {
    logic signed [31:0] look_x;
    logic signed [31:0] look_y;
    logic signed [31:0] look_z;
    logic        [31:0] heading;
    logic signed [30:0] elevation;
  } look_t;

  logic        [GAIN_W-1:0] gain_st;
  logic        [31:0]       heading_st;
  logic signed [31:0]       pitch_st;
  look_t                    look_q[$];
  int                       mismatches;
  int                       results_seen;

  assign fail_count_o = mismatches;
  assign results_o    = results_seen;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic void cordic_sin_cos(input logic [31:0] ang, output longint c,
                                         output longint s);
    logic [1:0]  quad;
    logic [31:0] red;
    longint      z, x, y, nx;
    int          i;
    quad = 2'((ang + 32'h2000_0000) >> 30);
    red  = ang - {quad, 30'd0};
    z = longint'($signed(red));
    x = UNIT_GAIN;
    y = 0;
    for (i = 0; i < int'(CORDIC_STEPS) && i < ATAN_DEPTH; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ATAN_TURNS[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ATAN_TURNS[i];
      end
      x = nx;
    end
    case (quad)
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic logic signed [31:0] sat_coord(input logic signed [31:0] base,
                                                   input longint delta);
    longint sum;
    sum = longint'(base) + delta;
    if (sum > INT32_MAX) sum = INT32_MAX;
    if (sum < INT32_MIN) sum = INT32_MIN;
    return 32'(sum);
  endfunction

  function automatic look_t predict_look(input logic signed [15:0] mx,
                                         input logic signed [15:0] my, input logic foc,
                                         input logic signed [31:0] ex,
                                         input logic signed [31:0] ey,
                                         input logic signed [31:0] ez);
    longint p, cp, sp, cy, sy;
    look_t  r;
    p = longint'(pitch_st);
    if (foc) begin
      heading_st = heading_st - 32'(longint'(mx) * longint'(gain_st));
      p = p - longint'(my) * longint'(gain_st);
    end
    if (p > ELEV_LIMIT) p = ELEV_LIMIT;
    if (p < -ELEV_LIMIT) p = -ELEV_LIMIT;
    pitch_st = 32'(p);
    cordic_sin_cos(32'(p), cp, sp);
    cordic_sin_cos(heading_st, cy, sy);
    r.look_x    = sat_coord(ex, (cp * sy + ROUND_XZ) >>> 44);
    r.look_y    = sat_coord(ey, (sp + ROUND_Y) >>> 14);
    r.look_z    = sat_coord(ez, (cp * cy + ROUND_XZ) >>> 44);
    r.heading   = heading_st;
    r.elevation = 31'(p);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    look_t want;
    if (!rst_ni) begin
      gain_st    = GAIN_RESET;
      heading_st = '0;
      pitch_st   = '0;
      look_q.delete();
      pending_o <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (look_q.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing expected (heading %h)",
                                    out_ch.heading));
        end else begin
          want = look_q.pop_front();
          if (out_ch.look_x !== want.look_x)
            report_mismatch($sformatf("look_x got %h expected %h", out_ch.look_x,
                                      want.look_x));
          if (out_ch.look_y !== want.look_y)
            report_mismatch($sformatf("look_y got %h expected %h", out_ch.look_y,
                                      want.look_y));
          if (out_ch.look_z !== want.look_z)
            report_mismatch($sformatf("look_z got %h expected %h", out_ch.look_z,
                                      want.look_z));
          if (out_ch.heading !== want.heading)
            report_mismatch($sformatf("heading got %h expected %h", out_ch.heading,
                                      want.heading));
          if (out_ch.elevation !== want.elevation)
            report_mismatch($sformatf("elevation got %h expected %h", out_ch.elevation,
                                      want.elevation));
        end
      end
      if (cfg_we_i) begin
        gain_st = cfg_wdata_i;
      end
      if (in_ch.valid && in_ch.ready) begin
        look_q.push_back(predict_look(in_ch.motion_x, in_ch.motion_y, in_ch.focused,
                                      in_ch.eye_x, in_ch.eye_y, in_ch.eye_z));
      end
      pending_o <= look_q.size();
    end
  end

endmodule

FILE: tb/sv/tb.sv
// Top of the look-direction testbench: clock, reset, stimulus, handshake pressure and verdict.
// Depends on ypld_pkg, ypld_if, yaw_pitch_look_direction and ypld_look_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ypld_pkg::*;

  localparam int                 CYCLE_LIMIT = 1000000;
  localparam int                 PHASES      = 8;
  localparam int                 PHASE_BEATS = 250;
  localparam logic signed [31:0] MAX32       = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MIN32       = 32'sh8000_0000;
  localparam logic signed [15:0] MAX16       = 16'sh7FFF;
  localparam logic signed [15:0] MIN16       = 16'sh8000;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we;
  logic [GAIN_W-1:0] cfg_wdata;
  int                fail_count;
  int                pending;
  int                results_seen;
  int                send_idle_pct;
  int                recv_stall_pct;
  int                hold_left;
  int                beats_sent;
  int                gains_written;
  int                cycle_count;
  logic [GAIN_W-1:0] gain_plan [PHASES];

  ypld_in_if  in_ch ();
  ypld_out_if out_ch ();

  yaw_pitch_look_direction DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  ypld_look_checker look_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results_seen)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_item(input logic signed [15:0] mx, input logic signed [15:0] my,
                           input logic foc, input logic signed [31:0] ex,
                           input logic signed [31:0] ey, input logic signed [31:0] ez);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.motion_x <= mx;
    in_ch.motion_y <= my;
    in_ch.focused  <= foc;
    in_ch.eye_x    <= ex;
    in_ch.eye_y    <= ey;
    in_ch.eye_z    <= ez;
    do @(posedge clk_i); while (!in_ch.ready);
    beats_sent++;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic set_gain(input logic [GAIN_W-1:0] g);
    cfg_we    <= 1'b1;
    cfg_wdata <= g;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    gains_written++;
  endtask

  task automatic set_profile(input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  function automatic logic signed [15:0] rand_motion();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return ($urandom_range(0, 1) != 0) ? MAX16 : MIN16;
      default: return 16'(int'($urandom_range(0, 128)) - 64);
    endcase
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return MAX32 - 32'($urandom_range(0, 131072));
      1: return MIN32 + 32'($urandom_range(0, 131072));
      2, 3: return 32'($urandom);
      default: return 32'(int'($urandom_range(0, 33554432)) - 16777216);
    endcase
  endfunction

  task automatic send_random();
    send_item(rand_motion(), rand_motion(), ($urandom_range(0, 9) != 0),
              rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic run_directed();
    send_item(0, 0, 1'b1, 0, 0, 0);
    send_item(0, 0, 1'b1, MAX32, MAX32, MAX32);
    send_item(0, 0, 1'b1, MIN32, MIN32, MIN32);
    send_item(MAX16, MIN16, 1'b0, 0, 0, 0);
    send_item(MAX16, 0, 1'b1, 32'sh0001_0000, 0, 0);
    send_item(MIN16, 0, 1'b1, 0, 0, 0);
    send_item(0, MAX16, 1'b1, 0, MIN32, 0);
    send_item(0, MIN16, 1'b1, 0, MAX32, 0);
    drain();
    set_gain(24'd65536);
    send_item(MIN16, 0, 1'b1, MIN32, MIN32, MIN32);
    send_item(MIN16, 0, 1'b1, MAX32, MAX32, MAX32);
    drain();
    set_gain(24'hFF_FFFF);
    send_item(0, MIN16, 1'b1, 0, MAX32, 0);
    send_item(0, MIN16, 1'b1, 0, MAX32, 0);
    send_item(MAX16, MAX16, 0, 0, MIN32, 0);
    send_item(MAX16, MAX16, 1'b1, 0, MIN32, 0);
    send_item(MIN16, 16'sd1, 1'b1, MAX32, MIN32, MIN32);
    send_item(16'sd1, MIN16, 1'b1, MIN32, MAX32, MAX32);
    drain();
    set_gain('0);
    send_item(MAX16, MIN16, 1'b1, 0, 0, 0);
    send_item(MIN16, MAX16, 1'b1, 0, 0, 0);
    drain();
    set_gain(24'd1);
    send_item(MAX16, MAX16, 1'b1, 0, 0, 0);
    send_item(16'sh5555, 16'shAAAA, 1'b1, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_F0F0);
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.motion_x = '0;
    in_ch.motion_y = '0;
    in_ch.focused  = 1'b0;
    in_ch.eye_x    = '0;
    in_ch.eye_y    = '0;
    in_ch.eye_z    = '0;
    out_ch.ready   = 1'b0;
    hold_left      = 0;
    beats_sent     = 0;
    gains_written  = 0;
    cycle_count    = 0;
    gain_plan[0]   = GAIN_RESET;
    gain_plan[1]   = 24'hFF_FFFF;
    gain_plan[2]   = '0;
    gain_plan[3]   = 24'd1;
    gain_plan[4]   = 24'($urandom);
    gain_plan[5]   = 24'($urandom_range(0, 65535));
    gain_plan[6]   = 24'hFF_FFFF;
    gain_plan[7]   = 24'($urandom_range(0, 8192));
    set_profile(0, 0);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      set_gain(gain_plan[ph]);
      case (ph % 4)
        0: set_profile(0, 0);
        1: set_profile(75, 0);
        2: set_profile(0, 75);
        default: set_profile(6, 6);
      endcase
      for (int n = 0; n < PHASE_BEATS; n++) begin
        send_random();
        if (n == PHASE_BEATS / 2 && ph == 3) drain();
      end
    end

    drain();
    set_profile(0, 0);
    hold_left = 600;
    repeat (20) send_random();
    drain();
    repeat (100) @(posedge clk_i);

    $display("Sent %0d input beats and checked %0d result beats over %0d gain writes,",
             beats_sent, results_seen, gains_written);
    $display("with four handshake profiles and a long output hold.");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
